/* hw/rtl/wps_pkg.sv */
// ----------------------------------------------------------------------------
// wps_pkg
// shared types and constants of the wav pcm stream parser
// ----------------------------------------------------------------------------
package wps_pkg;

  // chunk tags as they appear in a shifted window, first byte highest
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RIFF     = 3'd1;
  localparam logic [2:0] ERR_WAVE     = 3'd2;
  localparam logic [2:0] ERR_NOT_MONO = 3'd3;
  localparam logic [2:0] ERR_DEPTH    = 3'd4;

  // format chunk length in bytes, including its size field
  localparam logic [4:0] FMT_LEN = 5'd20;

  // output payload width, packed to whole bytes
  localparam int OUT_DATA_W = 88;

  // per-byte datapath operation
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TAG,
    OP_SKIP,
    OP_SEEK,
    OP_FMT,
    OP_DSIZE,
    OP_SAMPLE
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic       clr;
    op_t        op;
    logic       seek_data;
    logic       div_start;
    logic       load_limit;
    logic       emit;
    logic [1:0] kind;
    logic [2:0] err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic fmt_last;
    logic seek_hit;
    logic win_riff;
    logic win_wave;
    logic mono;
    logic depth_ok;
    logic smp_last;
    logic smp_fin;
    logic div_done;
    logic quot_zero;
    logic total_zero;
  } sts_t;

endpackage

/* hw/rtl/wps_div.sv */
// ----------------------------------------------------------------------------
// wps_div
// restoring divider, one quotient bit per cycle, 32 by 16 bits
// ----------------------------------------------------------------------------
module wps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r,  busy_nxt;
  logic        done_r,  done_nxt;
  logic [4:0]  cnt_r,   cnt_nxt;
  logic [31:0] quot_r,  quot_nxt;
  logic [15:0] rem_r,   rem_nxt;
  logic [16:0] shifted;
  logic        fits;

  // a zero divisor always fits, so the quotient comes out all ones
  assign shifted = {rem_r, quot_r[31]};
  assign fits    = shifted >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? 16'(shifted - {1'b0, divisor}) : shifted[15:0];
      quot_nxt = {quot_r[30:0], fits};
      cnt_nxt  = 5'(cnt_r + 5'd1);
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

/* hw/rtl/wps_dp.sv */
// ----------------------------------------------------------------------------
// wps_dp
// parser datapath: tag window, header fields, sample assembly, result register
// ----------------------------------------------------------------------------
module wps_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    data_byte,
  input  wps_pkg::cmd_t                 cmd,
  input  logic                          out_ready,
  output wps_pkg::sts_t                 sts,
  output logic                          out_valid,
  output logic [1:0]                    out_kind,
  output logic [wps_pkg::OUT_DATA_W-1:0] out_data,
  output logic                          out_last
);

  import wps_pkg::*;

  logic [4:0]  cnt_r,   cnt_nxt,   cnt_b;
  logic [31:0] win_r,   win_nxt,   win_b;
  logic [31:0] asm_r,   asm_nxt,   asm_b;
  logic [15:0] ch_r,    ch_nxt,    ch_b;
  logic [15:0] align_r, align_nxt, align_b;
  logic [15:0] depth_r, depth_nxt, depth_b;
  logic [31:0] rate_r,  rate_nxt,  rate_b;
  logic [31:0] total_r, total_nxt, total_b;
  logic [31:0] limit_r, limit_nxt, limit_b;
  logic [31:0] seen_r,  seen_nxt,  seen_b;
  logic [31:0] emit_r,  emit_nxt,  emit_b;

  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r;
  logic [2:0]  oerr_r;
  logic [31:0] osmp_r, orate_r;
  logic [15:0] obps_r;
  logic        olast_r;

  logic [31:0] win_sh, asm_new, total_new, seen_new, emit_new, lj, smp_v;
  logic [4:0]  cnt_inc, cnt_sat;
  logic [4:0]  nbytes;
  logic [31:0] byte_pos;
  logic        div_done;
  logic [31:0] quotient;

  // start of file sees every register as cleared
  always_comb begin
    cnt_b   = cmd.clr ? '0 : cnt_r;
    win_b   = cmd.clr ? '0 : win_r;
    asm_b   = cmd.clr ? '0 : asm_r;
    ch_b    = cmd.clr ? '0 : ch_r;
    align_b = cmd.clr ? '0 : align_r;
    depth_b = cmd.clr ? '0 : depth_r;
    rate_b  = cmd.clr ? '0 : rate_r;
    total_b = cmd.clr ? '0 : total_r;
    limit_b = cmd.clr ? '0 : limit_r;
    seen_b  = cmd.clr ? '0 : seen_r;
    emit_b  = cmd.clr ? '0 : emit_r;
  end

  assign win_sh    = {win_b[23:0], data_byte};
  assign cnt_inc   = 5'(cnt_b + 5'd1);
  assign cnt_sat   = (cnt_b < 5'd4) ? cnt_inc : cnt_b;
  assign byte_pos  = {24'd0, data_byte} << {cnt_b[1:0], 3'b000};
  assign asm_new   = asm_b | byte_pos;
  assign total_new = total_b | byte_pos;
  assign seen_new  = (seen_b == '1) ? seen_b : 32'(seen_b + 32'd1);
  assign emit_new  = 32'(emit_b + 32'd1);
  assign nbytes    = {2'b00, depth_b[5:3]};

  // left-justify by depth, then halve keeping the sign
  always_comb begin
    case (depth_b)
      16'd16:  lj = {asm_new[15:0], 16'd0};
      16'd24:  lj = {asm_new[23:0], 8'd0};
      default: lj = asm_new;
    endcase
    smp_v = {lj[31], lj[31:1]};
  end

  always_comb begin
    sts            = '0;
    sts.cnt_last   = cnt_b == 5'd3;
    sts.fmt_last   = cnt_b == 5'(FMT_LEN - 5'd1);
    sts.seek_hit   = (cnt_sat >= 5'd4) &&
                     (win_sh == (cmd.seek_data ? TAG_DATA : TAG_FMT));
    sts.win_riff   = win_sh == TAG_RIFF;
    sts.win_wave   = win_sh == TAG_WAVE;
    sts.mono       = ch_b == 16'd1;
    sts.depth_ok   = (depth_b == 16'd16) || (depth_b == 16'd24) || (depth_b == 16'd32);
    sts.smp_last   = cnt_inc == nbytes;
    sts.smp_fin    = (emit_new >= limit_b) || (seen_new >= total_b);
    sts.div_done   = div_done;
    sts.quot_zero  = quotient == '0;
    sts.total_zero = total_b == '0;
  end

  always_comb begin
    cnt_nxt   = cnt_b;
    win_nxt   = win_b;
    asm_nxt   = asm_b;
    ch_nxt    = ch_b;
    align_nxt = align_b;
    depth_nxt = depth_b;
    rate_nxt  = rate_b;
    total_nxt = total_b;
    limit_nxt = limit_b;
    seen_nxt  = seen_b;
    emit_nxt  = emit_b;
    unique case (cmd.op)
      OP_TAG: begin
        win_nxt = win_sh;
        cnt_nxt = cnt_inc;
        if (sts.cnt_last) begin
          win_nxt = '0;
          cnt_nxt = '0;
        end
      end
      OP_SKIP: begin
        cnt_nxt = cnt_inc;
        if (sts.cnt_last) begin
          win_nxt = '0;
          cnt_nxt = '0;
        end
      end
      OP_SEEK: begin
        win_nxt = win_sh;
        cnt_nxt = sts.seek_hit ? '0 : cnt_sat;
        if (sts.seek_hit && cmd.seek_data) total_nxt = '0;
      end
      OP_FMT: begin
        case (cnt_b)
          5'd6:    ch_nxt[7:0]     = ch_b[7:0] | data_byte;
          5'd7:    ch_nxt[15:8]    = ch_b[15:8] | data_byte;
          5'd8:    rate_nxt[7:0]   = rate_b[7:0] | data_byte;
          5'd9:    rate_nxt[15:8]  = rate_b[15:8] | data_byte;
          5'd10:   rate_nxt[23:16] = rate_b[23:16] | data_byte;
          5'd11:   rate_nxt[31:24] = rate_b[31:24] | data_byte;
          5'd16:   align_nxt[7:0]  = align_b[7:0] | data_byte;
          5'd17:   align_nxt[15:8] = align_b[15:8] | data_byte;
          5'd18:   depth_nxt[7:0]  = depth_b[7:0] | data_byte;
          5'd19:   depth_nxt[15:8] = depth_b[15:8] | data_byte;
          default: ;
        endcase
        cnt_nxt = cnt_inc;
        if (sts.fmt_last) begin
          cnt_nxt = '0;
          win_nxt = '0;
        end
      end
      OP_DSIZE: begin
        total_nxt = total_new;
        cnt_nxt   = cnt_inc;
        if (sts.cnt_last) begin
          cnt_nxt  = '0;
          asm_nxt  = '0;
          seen_nxt = '0;
          emit_nxt = '0;
        end
      end
      OP_SAMPLE: begin
        asm_nxt  = asm_new;
        cnt_nxt  = cnt_inc;
        seen_nxt = seen_new;
        if (sts.smp_last) begin
          emit_nxt = emit_new;
          cnt_nxt  = '0;
          asm_nxt  = '0;
        end
      end
      default: ;
    endcase
    if (cmd.load_limit) limit_nxt = quotient;
  end

  // header division: data size over block align
  wps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (total_new),
    .divisor  (align_b),
    .done     (div_done),
    .quotient (quotient)
  );

  assign ov_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      win_r   <= '0;
      asm_r   <= '0;
      ch_r    <= '0;
      align_r <= '0;
      depth_r <= '0;
      rate_r  <= '0;
      total_r <= '0;
      limit_r <= '0;
      seen_r  <= '0;
      emit_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      win_r   <= win_nxt;
      asm_r   <= asm_nxt;
      ch_r    <= ch_nxt;
      align_r <= align_nxt;
      depth_r <= depth_nxt;
      rate_r  <= rate_nxt;
      total_r <= total_nxt;
      limit_r <= limit_nxt;
      seen_r  <= seen_nxt;
      emit_r  <= emit_nxt;
      ov_r    <= ov_nxt;
    end
    if (cmd.emit) begin
      okind_r <= cmd.kind;
      oerr_r  <= cmd.err;
      osmp_r  <= (cmd.kind == KIND_SAMPLE) ? smp_v : '0;
      olast_r <= (cmd.kind == KIND_SAMPLE) ? sts.smp_fin : 1'b0;
      orate_r <= (cmd.kind == KIND_HEADER) ? rate_b : '0;
      obps_r  <= (cmd.kind == KIND_HEADER) ? depth_b : '0;
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_last  = olast_r;
  assign out_data  = {5'd0, obps_r, orate_r, osmp_r, oerr_r};

endmodule

/* hw/rtl/wps_ctrl.sv */
// ----------------------------------------------------------------------------
// wps_ctrl
// parse phase state machine, issues one datapath command per request
// ----------------------------------------------------------------------------
module wps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          start_file,
  input  logic          out_free,
  input  wps_pkg::sts_t sts,
  output logic          in_ready,
  output wps_pkg::cmd_t cmd
);

  import wps_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_SKIPSIZE,
    PH_WAVE,
    PH_SEEKFMT,
    PH_FMT,
    PH_SEEKDATA,
    PH_DSIZE,
    PH_DIVIDE,
    PH_SAMPLES,
    PH_DONE
  } phase_t;

  phase_t phase_r, phase_nxt, phase_eff;
  logic   accept;

  assign in_ready  = (phase_r != PH_DIVIDE) && out_free;
  assign accept    = in_valid && in_ready;
  assign phase_eff = (accept && start_file) ? PH_RIFF : phase_r;

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.kind  = KIND_SAMPLE;
    cmd.err   = ERR_NONE;
    cmd.clr   = accept && start_file;
    phase_nxt = phase_eff;
    if (phase_r == PH_DIVIDE) begin
      if (sts.div_done && out_free) begin
        cmd.load_limit = 1'b1;
        cmd.emit       = 1'b1;
        cmd.kind       = KIND_HEADER;
        phase_nxt      = (sts.quot_zero || sts.total_zero) ? PH_DONE : PH_SAMPLES;
      end
    end else if (accept) begin
      unique case (phase_eff)
        PH_RIFF: begin
          cmd.op = OP_TAG;
          if (sts.cnt_last) begin
            if (sts.win_riff) begin
              phase_nxt = PH_SKIPSIZE;
            end else begin
              cmd.emit  = 1'b1;
              cmd.kind  = KIND_ERROR;
              cmd.err   = ERR_RIFF;
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_SKIPSIZE: begin
          cmd.op = OP_SKIP;
          if (sts.cnt_last) phase_nxt = PH_WAVE;
        end
        PH_WAVE: begin
          cmd.op = OP_TAG;
          if (sts.cnt_last) begin
            if (sts.win_wave) begin
              phase_nxt = PH_SEEKFMT;
            end else begin
              cmd.emit  = 1'b1;
              cmd.kind  = KIND_ERROR;
              cmd.err   = ERR_WAVE;
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_SEEKFMT: begin
          cmd.op = OP_SEEK;
          if (sts.seek_hit) phase_nxt = PH_FMT;
        end
        PH_FMT: begin
          cmd.op = OP_FMT;
          if (sts.fmt_last) begin
            if (sts.mono) begin
              phase_nxt = PH_SEEKDATA;
            end else begin
              cmd.emit  = 1'b1;
              cmd.kind  = KIND_ERROR;
              cmd.err   = ERR_NOT_MONO;
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_SEEKDATA: begin
          cmd.op        = OP_SEEK;
          cmd.seek_data = 1'b1;
          if (sts.seek_hit) phase_nxt = PH_DSIZE;
        end
        PH_DSIZE: begin
          cmd.op = OP_DSIZE;
          if (sts.cnt_last) begin
            if (sts.depth_ok) begin
              cmd.div_start = 1'b1;
              phase_nxt     = PH_DIVIDE;
            end else begin
              cmd.emit  = 1'b1;
              cmd.kind  = KIND_ERROR;
              cmd.err   = ERR_DEPTH;
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_SAMPLES: begin
          cmd.op = OP_SAMPLE;
          if (sts.smp_last) begin
            cmd.emit = 1'b1;
            if (sts.smp_fin) phase_nxt = PH_DONE;
          end
        end
        PH_DONE:   ;
        PH_DIVIDE: ;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

/* hw/rtl/wav_pcm_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser_core
// byte-serial wav header parser and mono pcm sample decoder
// ----------------------------------------------------------------------------
// usage:
//   the input channel takes one file byte per request; in_tuser marks the
//   first byte of a new file and clears all parse state before that byte
//   the result channel carries at most one result per input byte: a header
//   accepted result (rate and depth), an error, or one decoded sample as
//   q1.31 at half scale; out_tlast flags the final sample of the data chunk
//   a result is registered and can be taken in the cycle after the
//   byte that completes it; the header accepted result waits on the divider
//   and can be taken once the division after the last data size byte ends
//   throughput: one byte per cycle while results are taken, except after the
//   last data size byte, where a bit-serial divider works out the sample
//   count limit and the input stalls there, once per file
//   when the receiver stalls, the result register holds and the input is
//   held off until that result is taken; a result can be taken and the
//   next byte accepted in the same cycle
//   after reset the parser waits for the riff tag; after an error or the
//   end of the data every byte is taken and dropped until a new file starts
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input request channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic [0:0]                     in_tuser,   // [0] start_file
  // result request channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [2:0] error_code, [34:3] sample_value, [66:35] sample_rate,
  // [82:67] bits_per_sample, [87:83] zero
  output logic [wps_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     out_tuser,  // [1:0] kind
  output logic                           out_tlast   // last sample of data chunk
);

  import wps_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_free;

  // the result register frees up when empty or when drained this cycle
  assign out_free = !out_tvalid || out_tready;

  // phase sequencing and result decisions
  wps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .start_file (in_tuser[0]),
    .out_free   (out_free),
    .sts        (sts),
    .in_ready   (in_tready),
    .cmd        (cmd)
  );

  // header fields, sample assembly, divider and result register
  wps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_tdata),
    .cmd       (cmd),
    .out_ready (out_tready),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_kind  (out_tuser),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

/* dv/tb_wav_pcm_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_wav_pcm_stream_parser_core
// self-checking bench for the byte-serial wav header parser and pcm decoder
// ----------------------------------------------------------------------------
// builds whole wav files byte by byte (clean files, broken tags, stereo and
// odd bit depths, missing chunks, cut-off headers, restarts, line noise),
// feeds them through the input request channel with random gaps and checks
// every result request against an in-bench parser model, field by field
// ----------------------------------------------------------------------------
module tb_wav_pcm_stream_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wps_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          LIVE_TARGET  = 1750;
  localparam int          SETTLE_CYCLES = 60;

  // parse stages of the in-bench model
  typedef enum logic [3:0] {
    P_RIFF, P_SKIP, P_WAVE, P_SEEK_FMT, P_FMT, P_SEEK_DATA, P_DSIZE, P_SAMPLES, P_DONE
  } parse_stage_t;

  // ways a generated file can be broken
  typedef enum logic [2:0] {
    CLEAN, BAD_RIFF, BAD_WAVE, NO_FMT, NO_DATA, CUT_SHORT
  } file_flaw_t;

  // one byte request, plus a flag that holds it back until all results are in
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       drain;
  } byte_req_t;

  // one decoded result as the block should present it
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [31:0] sample;
    logic [31:0] rate;
    logic [15:0] depth;
    logic        fin;
  } parse_result_t;

  // header fields and shape of one generated file
  typedef struct {
    logic [15:0] chans;
    logic [15:0] balign;
    logic [15:0] depth;
    logic [31:0] rate;
    logic [31:0] dsize;
    int          junk_fmt;
    int          junk_data;
    file_flaw_t  flaw;
    bit          start;
    bit          drain;
  } wav_shape_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  wav_pcm_stream_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // stimulus and expectations
  byte_req_t     file_bytes[$];
  parse_result_t results_due[$];
  logic [7:0]    hdr_q[$];

  // parser model state
  parse_stage_t stage;
  int unsigned  byte_cnt;
  logic [31:0]  tag_window;
  logic [31:0]  sample_acc;
  logic [15:0]  fmt_chans;
  logic [15:0]  fmt_align;
  logic [15:0]  fmt_depth;
  logic [31:0]  fmt_rate;
  logic [31:0]  data_size;
  logic [31:0]  sample_cap;
  logic [31:0]  data_seen;
  logic [31:0]  samples_out;

  // bookkeeping
  int          fail_count = 0;
  int          n_files = 0;
  int          n_bytes = 0;
  int          n_samples = 0;
  int          n_headers = 0;
  int          n_errors = 0;
  int unsigned cycles = 0;
  logic        in_fire = 1'b0;
  int          send_gap = 0;
  int          hold_left = 0;
  int          calm_left = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  task automatic clear_parse();
    stage       = P_RIFF;
    byte_cnt    = 0;
    tag_window  = '0;
    sample_acc  = '0;
    fmt_chans   = '0;
    fmt_align   = '0;
    fmt_depth   = '0;
    fmt_rate    = '0;
    data_size   = '0;
    sample_cap  = '0;
    data_seen   = '0;
    samples_out = '0;
  endtask

  // advance the model by one accepted byte; got is set when a result follows
  task automatic decode_byte(input logic [7:0] b, input logic first,
                             output bit got, output parse_result_t res);
    logic [31:0] lj;
    int unsigned nbytes;
    res = '0;
    got = 1'b0;
    if (first) clear_parse();
    case (stage)
      P_RIFF, P_WAVE: begin
        tag_window = {tag_window[23:0], b};
        byte_cnt++;
        if (byte_cnt >= 4) begin
          if (tag_window != ((stage == P_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
            res.kind = KIND_ERROR;
            res.err  = (stage == P_RIFF) ? ERR_RIFF : ERR_WAVE;
            got      = 1'b1;
            stage    = P_DONE;
          end else begin
            stage      = (stage == P_RIFF) ? P_SKIP : P_SEEK_FMT;
            byte_cnt   = 0;
            tag_window = '0;
          end
        end
      end
      // riff size is not used
      P_SKIP: begin
        byte_cnt++;
        if (byte_cnt >= 4) begin
          stage      = P_WAVE;
          byte_cnt   = 0;
          tag_window = '0;
        end
      end
      // sliding window, only compared once it holds four bytes
      P_SEEK_FMT, P_SEEK_DATA: begin
        tag_window = {tag_window[23:0], b};
        if (byte_cnt < 4) byte_cnt++;
        if (byte_cnt >= 4 &&
            tag_window == ((stage == P_SEEK_FMT) ? TAG_FMT : TAG_DATA)) begin
          byte_cnt = 0;
          if (stage == P_SEEK_FMT) begin
            stage = P_FMT;
          end else begin
            stage     = P_DSIZE;
            data_size = '0;
          end
        end
      end
      // chunk size, format and byte rate pass by unused
      P_FMT: begin
        case (byte_cnt)
          6, 7:          fmt_chans |= 16'(b) << (8 * (byte_cnt - 6));
          8, 9, 10, 11:  fmt_rate  |= 32'(b) << (8 * (byte_cnt - 8));
          16, 17:        fmt_align |= 16'(b) << (8 * (byte_cnt - 16));
          18, 19:        fmt_depth |= 16'(b) << (8 * (byte_cnt - 18));
          default: ;
        endcase
        byte_cnt++;
        if (byte_cnt >= FMT_LEN) begin
          if (fmt_chans != 16'd1) begin
            res.kind = KIND_ERROR;
            res.err  = ERR_NOT_MONO;
            got      = 1'b1;
            stage    = P_DONE;
          end else begin
            stage      = P_SEEK_DATA;
            byte_cnt   = 0;
            tag_window = '0;
          end
        end
      end
      P_DSIZE: begin
        data_size |= 32'(b) << (8 * (byte_cnt & 3));
        byte_cnt++;
        if (byte_cnt >= 4) begin
          got = 1'b1;
          if (fmt_depth != 16 && fmt_depth != 24 && fmt_depth != 32) begin
            res.kind = KIND_ERROR;
            res.err  = ERR_DEPTH;
            stage    = P_DONE;
          end else begin
            // zero block align leaves only the data size to end the run
            sample_cap  = (fmt_align != 0) ? data_size / 32'(fmt_align) : '1;
            res.kind    = KIND_HEADER;
            res.rate    = fmt_rate;
            res.depth   = fmt_depth;
            byte_cnt    = 0;
            sample_acc  = '0;
            data_seen   = '0;
            samples_out = '0;
            stage = (sample_cap == 0 || data_size == 0) ? P_DONE : P_SAMPLES;
          end
        end
      end
      P_SAMPLES: begin
        nbytes = fmt_depth / 8;
        sample_acc |= 32'(b) << (8 * (byte_cnt & 3));
        byte_cnt++;
        if (data_seen != '1) data_seen++;
        if (byte_cnt >= nbytes) begin
          // left-justify, then halve with the sign kept
          lj = sample_acc << ((32 - fmt_depth) & 31);
          samples_out++;
          res.kind   = KIND_SAMPLE;
          res.sample = {lj[31], lj[31:1]};
          res.fin    = (samples_out >= sample_cap || data_seen >= data_size);
          got        = 1'b1;
          byte_cnt   = 0;
          sample_acc = '0;
          if (res.fin) stage = P_DONE;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // file builder
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] data, input logic start, input logic drain);
    file_bytes.push_back('{data: data, start: start, drain: drain});
  endtask

  // little-endian word straight into the byte stream
  task automatic push_word(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) push_byte(v[8*i +: 8], 1'b0, 1'b0);
  endtask

  // random bytes, optionally with stray restart flags
  task automatic push_noise(input int n, input bit restarts);
    for (int i = 0; i < n; i++)
      push_byte(8'($urandom_range(0, 255)), restarts && $urandom_range(0, 5) == 0, 1'b0);
  endtask

  // pcm payload, biased toward the extreme byte values
  task automatic push_samples(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        2:       b = 8'h80;
        3:       b = 8'h7F;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_byte(b, 1'b0, 1'b0);
    end
  endtask

  task automatic hdr_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) hdr_q.push_back(tag[8*i +: 8]);
  endtask

  task automatic hdr_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) hdr_q.push_back(v[8*i +: 8]);
  endtask

  // filler chunk; half the time it ends in the first two bytes of the next
  // tag so the window has to slide past a partial match
  task automatic hdr_junk(input int n, input logic [31:0] next_tag);
    bit decoy;
    decoy = n >= 2 && $urandom_range(0, 1) == 1;
    for (int i = 0; i < n - (decoy ? 2 : 0); i++) hdr_q.push_back(8'($urandom_range(0, 255)));
    if (decoy) begin
      hdr_q.push_back(next_tag[31:24]);
      hdr_q.push_back(next_tag[23:16]);
    end
  endtask

  // queue the header of one file up to its data size, broken as asked
  task automatic queue_header(input wav_shape_t s, output int n_sent);
    logic [31:0] tag;
    int          cut;
    hdr_q.delete();
    tag = TAG_RIFF;
    if (s.flaw == BAD_RIFF) tag ^= 32'(1) << $urandom_range(0, 31);
    hdr_tag(tag);
    hdr_le($urandom, 4);
    tag = TAG_WAVE;
    if (s.flaw == BAD_WAVE) tag ^= 32'(1) << $urandom_range(0, 31);
    hdr_tag(tag);
    hdr_junk(s.junk_fmt, TAG_FMT);
    if (s.flaw != NO_FMT) begin
      hdr_tag(TAG_FMT);
      hdr_le(32'd16, 4);
      hdr_le(32'd1, 2);
      hdr_le(32'(s.chans), 2);
      hdr_le(s.rate, 4);
      hdr_le($urandom, 4);
      hdr_le(32'(s.balign), 2);
      hdr_le(32'(s.depth), 2);
      hdr_junk(s.junk_data, TAG_DATA);
      if (s.flaw != NO_DATA) begin
        hdr_tag(TAG_DATA);
        hdr_le(s.dsize, 4);
      end
    end
    cut = (s.flaw == CUT_SHORT) ? $urandom_range(1, hdr_q.size() - 1) : hdr_q.size();
    for (int i = 0; i < cut; i++) push_byte(hdr_q[i], s.start && i == 0, s.drain && i == 0);
    n_sent = cut;
    n_files++;
  endtask

  function automatic wav_shape_t mono(input logic [15:0] depth_bits,
                                      input logic [15:0] align,
                                      input logic [31:0] size);
    wav_shape_t s;
    s.chans     = 16'd1;
    s.balign    = align;
    s.depth     = depth_bits;
    s.rate      = 32'd48000;
    s.dsize     = size;
    s.junk_fmt  = 0;
    s.junk_data = 0;
    s.flaw      = CLEAN;
    s.start     = 1'b1;
    s.drain     = 1'b0;
    return s;
  endfunction

  function automatic wav_shape_t random_shape();
    wav_shape_t s;
    int         r;
    s = mono(16'(8 * $urandom_range(2, 4)), 16'd0, 32'd0);
    s.balign = s.depth / 8;
    s.rate   = $urandom;
    r = $urandom_range(0, 99);
    if (r < 70)      s.dsize = $urandom_range(0, 40);
    else if (r < 90) s.dsize = 32'(s.balign) * $urandom_range(1, 16);
    else             s.dsize = $urandom;
    // odd depths and block aligns
    if ($urandom_range(0, 11) == 0) s.depth = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 12)      s.balign = 16'($urandom_range(0, 8));
    else if (r < 15) s.balign = 16'hFFFF;
    else if (r < 18) s.balign = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 15) == 0) s.chans = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 2) == 0) s.junk_fmt = $urandom_range(1, 24);
    if ($urandom_range(0, 2) == 0) s.junk_data = $urandom_range(1, 24);
    r = $urandom_range(0, 99);
    if (r < 80)      s.flaw = CLEAN;
    else if (r < 84) s.flaw = BAD_RIFF;
    else if (r < 88) s.flaw = BAD_WAVE;
    else if (r < 91) s.flaw = NO_FMT;
    else if (r < 94) s.flaw = NO_DATA;
    else             s.flaw = CUT_SHORT;
    s.start = $urandom_range(0, 19) != 0;
    s.drain = $urandom_range(0, 15) == 0;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      note_failure($sformatf("result %0d %s got 0x%0h want 0x%0h",
                             n_samples + n_headers + n_errors, field, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // random idle lengths: mostly none or short, a few long
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: input requests and result backpressure, changed on the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : driver
    byte_req_t req;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      // stretches with no idling on either side
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 149) == 0) calm_left = $urandom_range(20, 80);

      // input side: hold an unaccepted byte, else idle or present the next one
      if (in_tvalid && !in_fire) begin
        // byte still waiting for in_tready
      end else if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (file_bytes.size() == 0 ||
                   (file_bytes[0].drain && results_due.size() != 0)) begin
        // out of stimulus, or holding off until every result has come back
        in_tvalid <= 1'b0;
      end else begin
        req = file_bytes.pop_front();
        in_tdata  <= req.data;
        in_tuser  <= req.start;
        in_tvalid <= 1'b1;
        send_gap  = (calm_left > 0) ? 0 : pick_gap();
      end

      // result side
      if (calm_left > 0) begin
        out_tready <= 1'b1;
      end else if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
        case ($urandom_range(0, 24))
          0, 1, 2, 3, 4: hold_left = $urandom_range(1, 3);
          5:             hold_left = $urandom_range(8, 40);
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted byte, checks every accepted result
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    bit            got;
    parse_result_t res;
    parse_result_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid === 1'b1 && in_tready === 1'b1) begin
      decode_byte(in_tdata, in_tuser[0], got, res);
      n_bytes++;
      if (got) results_due.push_back(res);
    end
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (results_due.size() == 0) begin
        note_failure($sformatf("result with none due, kind %0d data 0x%0h",
                               out_tuser, out_tdata));
      end else begin
        want = results_due.pop_front();
        compare_field("kind", 32'(out_tuser), 32'(want.kind));
        compare_field("error_code", 32'(out_tdata[2:0]), 32'(want.err));
        compare_field("sample_value", out_tdata[34:3], want.sample);
        compare_field("sample_rate", out_tdata[66:35], want.rate);
        compare_field("bits_per_sample", 32'(out_tdata[82:67]), 32'(want.depth));
        compare_field("pad", 32'(out_tdata[OUT_DATA_W-1:83]), 32'd0);
        compare_field("last", 32'(out_tlast), 32'(want.fin));
        case (want.kind)
          KIND_SAMPLE: n_samples++;
          KIND_HEADER: n_headers++;
          default:     n_errors++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, results_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin : main
    wav_shape_t s;
    int         sent;
    int         live;
    int         d;
    clear_parse();

    // 16-bit extremes, straight out of reset with no restart flag,
    // trailing bytes after the last sample are dropped
    s = mono(16'd16, 16'd2, 32'd8);
    s.start = 1'b0;
    s.rate  = '1;
    queue_header(s, sent);
    push_word(32'h8000, 2);
    push_word(32'h7FFF, 2);
    push_word(32'hFFFF, 2);
    push_word(32'h0000, 2);
    push_noise(2, 1'b0);

    // 24-bit extremes, sender waits for the previous file to drain
    s = mono(16'd24, 16'd3, 32'd9);
    s.rate  = '0;
    s.drain = 1'b1;
    queue_header(s, sent);
    push_word(32'h80_0000, 3);
    push_word(32'h7F_FFFF, 3);
    push_word(32'h00_0001, 3);

    // 32-bit, halving drops the odd lsb; filler chunks before fmt and data
    s = mono(16'd32, 16'd4, 32'd12);
    s.junk_fmt  = 6;
    s.junk_data = 10;
    queue_header(s, sent);
    push_word(32'h8000_0000, 4);
    push_word(32'h7FFF_FFFF, 4);
    push_word(32'h0000_0001, 4);

    // bad tags; bytes after an error are dropped
    s = mono(16'd16, 16'd2, 32'd4);
    s.flaw = BAD_RIFF;
    queue_header(s, sent);
    push_noise(3, 1'b0);
    s.flaw = BAD_WAVE;
    queue_header(s, sent);

    // not mono: stereo and zero channels
    s = mono(16'd16, 16'd2, 32'd4);
    s.chans = 16'd2;
    queue_header(s, sent);
    push_samples(4);
    s.chans = 16'd0;
    queue_header(s, sent);

    // unsupported depths
    s = mono(16'd8, 16'd1, 32'd4);
    queue_header(s, sent);
    push_samples(4);
    s = mono(16'hFFFF, 16'd2, 32'd4);
    queue_header(s, sent);

    // zero block align: only the data size ends the samples
    s = mono(16'd16, 16'd0, 32'd5);
    queue_header(s, sent);
    push_samples(6);

    // empty data, then a sample count of zero
    s = mono(16'd16, 16'd2, 32'd0);
    queue_header(s, sent);
    push_noise(2, 1'b0);
    s = mono(16'd16, 16'hFFFF, 32'd4);
    queue_header(s, sent);
    push_samples(4);

    // the final sample runs past the data size
    s = mono(16'd24, 16'd1, 32'd4);
    queue_header(s, sent);
    push_samples(6);

    // restart in the middle of samples, a missing fmt, a missing data, a cut header
    s = mono(16'd16, 16'd2, 32'd40);
    queue_header(s, sent);
    push_samples(5);
    s = mono(16'd16, 16'd2, 32'd4);
    s.flaw     = NO_FMT;
    s.junk_fmt = 30;
    queue_header(s, sent);
    s.flaw      = NO_DATA;
    s.junk_data = 30;
    queue_header(s, sent);
    s.flaw = CUT_SHORT;
    queue_header(s, sent);

    // data size of all ones, cut off by the next file
    s = mono(16'd32, 16'd4, '1);
    queue_header(s, sent);
    push_samples(16);

    // random files, mostly well formed, with noise in between
    live = file_bytes.size();
    while (live < LIVE_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        push_noise($urandom_range(1, 12), 1'b1);
      end else begin
        s = random_shape();
        queue_header(s, sent);
        if (s.dsize <= 64) d = int'(s.dsize) + $urandom_range(0, 4);
        else d = $urandom_range(8, 64);
        if ($urandom_range(0, 9) == 0) d = $urandom_range(0, d);
        push_samples(d);
        live += sent + ((s.dsize < 32'(d)) ? int'(s.dsize) : d);
      end
    end

    // hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for the last byte and the last result, then let the block settle
    while (file_bytes.size() != 0 || in_tvalid || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d files in %0d byte requests; checked %0d headers, %0d samples, %0d errors",
             n_files, n_bytes, n_headers, n_samples, n_errors);
    $display("covered 16/24/32-bit pcm, bad tags, stereo, odd depths, zero align, ",
             "empty data, restarts and noise");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
